/* hdl/gtd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtd_pkg
// Shared types, constants and the spread function of the grid diffusion block.
// ----------------------------------------------------------------------------
package gtd_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int ADDR_W     = COL_W + ROW_W;
	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
	localparam int LVL_W      = 8;
	localparam int SIZE_W     = 7;
	localparam int SPREAD_W   = LVL_W - 3;
	localparam int NET_W      = 10;
	localparam int STEP_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 16;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_THRESHOLD = 2'd0;
	localparam cfg_idx_t REG_WIDTH     = 2'd1;
	localparam cfg_idx_t REG_HEIGHT    = 2'd2;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_READ  = 1'b1;

	// fetch steps: own cell, then right, left, down, up neighbours
	typedef logic [STEP_W-1:0] step_t;
	localparam step_t STEP_OWN   = 3'd0;
	localparam step_t STEP_RIGHT = 3'd1;
	localparam step_t STEP_LEFT  = 3'd2;
	localparam step_t STEP_DOWN  = 3'd3;
	localparam step_t STEP_UP    = 3'd4;
	localparam step_t STEP_LAST  = 3'd5;

	typedef struct packed {
		logic [LVL_W-1:0]  thr;
		logic [SIZE_W-1:0] width;
		logic [SIZE_W-1:0] height;
	} grid_cfg_t;

	typedef struct packed {
		logic             blocked;
		logic [LVL_W-1:0] level;
	} cell_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		cell_t             wdata;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	typedef struct packed {
		logic idle;
		logic finishing;
	} stc_status_t;

	function automatic logic [SPREAD_W-1:0] spread_of(input logic [LVL_W-1:0] lvl,
		input logic [LVL_W-1:0] thr);
		logic [LVL_W-1:0] diff;
		diff = lvl - thr;
		spread_of = (lvl > thr) ? diff[LVL_W-1:3] : '0;
	endfunction

endpackage

/* hdl/grid_threshold_diffusion_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_threshold_diffusion_top
// Four-neighbour threshold diffusion over a stored 64 x 64 grid of levels.
// ----------------------------------------------------------------------------
// write transaction: taken with no result, next item taken the cycle after
// read transaction: result registered at the finish step, which waits while an
//   earlier result is held; cell and four neighbours share one memory read port
// one item at a time; a finished result may wait while the next item is taken
// reset: registers to defaults, then a clearing pass over the 4096 entries of the
//   cell store during which s_tready stays low (cfg writes still taken)
module grid_threshold_diffusion_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [gtd_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [7:0]                           cfg_data,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// col[5:0], row[11:6], level[19:12], blocked[20], zero pad
	input  logic [gtd_pkg::IN_DATA_W-1:0]        s_tdata,
	// action[0]
	input  logic                                 s_tuser,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// diffused level[7:0], changed[8], zero pad
	output logic [gtd_pkg::OUT_DATA_W-1:0]       m_tdata
);

	logic [gtd_pkg::LVL_W-1:0]   thr_q;
	logic [gtd_pkg::SIZE_W-1:0]  width_q;
	logic [gtd_pkg::SIZE_W-1:0]  height_q;
	gtd_pkg::grid_cfg_t          cfg;
	gtd_pkg::mem_req_t           mem_req;
	gtd_pkg::cell_t              rd_data;
	gtd_pkg::stc_status_t        status;
	logic                        clear_busy;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q    <= 8'd64;
			width_q  <= 7'd64;
			height_q <= 7'd64;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				gtd_pkg::REG_THRESHOLD: thr_q    <= cfg_data;
				gtd_pkg::REG_WIDTH:     width_q  <= cfg_data[gtd_pkg::SIZE_W-1:0];
				gtd_pkg::REG_HEIGHT:    height_q <= cfg_data[gtd_pkg::SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	// zero acts as one, oversize clips to the store
	always_comb begin
		cfg.thr = thr_q;
		if (width_q == '0) begin
			cfg.width = gtd_pkg::SIZE_W'(1);
		end else if (width_q > gtd_pkg::SIZE_W'(gtd_pkg::MAX_WIDTH)) begin
			cfg.width = gtd_pkg::SIZE_W'(gtd_pkg::MAX_WIDTH);
		end else begin
			cfg.width = width_q;
		end
		if (height_q == '0) begin
			cfg.height = gtd_pkg::SIZE_W'(1);
		end else if (height_q > gtd_pkg::SIZE_W'(gtd_pkg::MAX_HEIGHT)) begin
			cfg.height = gtd_pkg::SIZE_W'(gtd_pkg::MAX_HEIGHT);
		end else begin
			cfg.height = height_q;
		end
	end

	gtd_cell_mem u_mem (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (mem_req),
		.rd_data    (rd_data),
		.clear_busy (clear_busy)
	);

	gtd_stencil u_stencil (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.clear_busy (clear_busy),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.mem_req    (mem_req),
		.rd_data    (rd_data),
		.status     (status)
	);

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clear_busy |-> !s_tready)
		else $error("input taken during clearing pass");

	a_accept_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> status.idle)
		else $error("input taken while sequencer busy");

	a_read_blocks_next: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && (s_tuser == gtd_pkg::ACT_READ)) |=> !s_tready)
		else $error("read transaction did not occupy the sequencer");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(status.finishing))
		else $error("result appeared outside the finish step");

endmodule

/* hdl/gtd_cell_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtd_cell_mem
// Cell store (level and blocked flag) with registered read and a clearing
// pass after reset.
// ----------------------------------------------------------------------------
module gtd_cell_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  gtd_pkg::mem_req_t req,
	output gtd_pkg::cell_t    rd_data,
	output logic              clear_busy
);

	gtd_pkg::cell_t                 mem_q [gtd_pkg::DEPTH];
	gtd_pkg::cell_t                 rd_q;
	logic [gtd_pkg::ADDR_W-1:0]     clr_q;
	logic                           clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_q <= clr_q + 1'b1;
			if (clr_q == gtd_pkg::ADDR_W'(gtd_pkg::DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem_q[clr_q] <= '0;
		end else if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rd_q <= mem_q[req.raddr];
	end

	assign rd_data    = rd_q;
	assign clear_busy = clr_busy_q;

endmodule

/* hdl/gtd_stencil.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtd_stencil
// Sequencer that fetches a cell and its neighbours one per cycle and
// accumulates the net change in a shared adder, plus the result register.
// ----------------------------------------------------------------------------
module gtd_stencil (
	input  logic                               clk,
	input  logic                               arst_n,
	input  gtd_pkg::grid_cfg_t                 cfg,
	input  logic                               clear_busy,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [gtd_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [gtd_pkg::OUT_DATA_W-1:0]     m_tdata,
	output gtd_pkg::mem_req_t                  mem_req,
	input  gtd_pkg::cell_t                     rd_data,
	output gtd_pkg::stc_status_t               status
);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_FETCH  = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

	state_t                              state_q;
	gtd_pkg::step_t                      step_q;
	logic [gtd_pkg::COL_W-1:0]           col_q;
	logic [gtd_pkg::ROW_W-1:0]           row_q;
	logic                                oob_q;
	logic [gtd_pkg::LVL_W-1:0]           own_q;
	logic [gtd_pkg::SPREAD_W-1:0]        own_sp_q;
	logic                                self_blk_q;
	logic signed [gtd_pkg::NET_W-1:0]    net_q;
	logic                                m_valid_q;
	logic [gtd_pkg::LVL_W-1:0]           lvl_out_q;
	logic                                changed_q;

	logic [gtd_pkg::COL_W-1:0]           in_col;
	logic [gtd_pkg::ROW_W-1:0]           in_row;
	logic [gtd_pkg::LVL_W-1:0]           in_level;
	logic                                in_blocked;
	logic                                accept;
	logic                                in_oob;
	gtd_pkg::step_t                      proc_step;
	logic                                nb_ok;
	logic [gtd_pkg::SPREAD_W-1:0]        nb_sp;
	logic signed [gtd_pkg::NET_W-1:0]    inflow;
	logic signed [gtd_pkg::NET_W-1:0]    outflow;
	logic signed [gtd_pkg::NET_W-1:0]    add_a;
	logic signed [gtd_pkg::NET_W-1:0]    add_b;
	logic signed [gtd_pkg::NET_W-1:0]    sum;
	logic [gtd_pkg::LVL_W-1:0]           clamped;
	logic [gtd_pkg::ADDR_W-1:0]          nb_addr;
	logic                                load_out;

	assign in_col     = s_tdata[5:0];
	assign in_row     = s_tdata[11:6];
	assign in_level   = s_tdata[19:12];
	assign in_blocked = s_tdata[20];

	assign s_tready = (state_q == ST_IDLE) && !clear_busy;
	assign accept   = s_tvalid && s_tready;
	assign in_oob   = ({1'b0, in_col} >= cfg.width) || ({1'b0, in_row} >= cfg.height);

	// neighbour address issued in this cycle
	always_comb begin
		case (step_q)
			gtd_pkg::STEP_RIGHT: nb_addr = {row_q, col_q + 1'b1};
			gtd_pkg::STEP_LEFT:  nb_addr = {row_q, col_q - 1'b1};
			gtd_pkg::STEP_DOWN:  nb_addr = {row_q + 1'b1, col_q};
			gtd_pkg::STEP_UP:    nb_addr = {row_q - 1'b1, col_q};
			default:             nb_addr = {row_q, col_q};
		endcase
	end

	assign mem_req.we    = accept && (s_tuser == gtd_pkg::ACT_WRITE);
	assign mem_req.waddr = {in_row, in_col};
	assign mem_req.wdata = '{blocked: in_blocked, level: in_level};
	assign mem_req.raddr = (state_q == ST_IDLE) ? {in_row, in_col} : nb_addr;

	// data on rd_data belongs to the step issued in the previous cycle
	assign proc_step = step_q - 1'b1;

	always_comb begin
		case (proc_step)
			gtd_pkg::STEP_RIGHT: nb_ok = ({1'b0, col_q} + 1'b1) < cfg.width;
			gtd_pkg::STEP_LEFT:  nb_ok = col_q != '0;
			gtd_pkg::STEP_DOWN:  nb_ok = ({1'b0, row_q} + 1'b1) < cfg.height;
			gtd_pkg::STEP_UP:    nb_ok = row_q != '0;
			default:             nb_ok = 1'b0;
		endcase
	end

	assign nb_sp   = gtd_pkg::spread_of(rd_data.level, cfg.thr);
	assign inflow  = (nb_ok && !self_blk_q) ?
		gtd_pkg::NET_W'(nb_sp) : '0;
	assign outflow = (nb_ok && !rd_data.blocked) ?
		gtd_pkg::NET_W'(own_sp_q) : '0;

	// shared adder: accumulates per neighbour, then adds the net to the own level
	always_comb begin
		if (state_q == ST_FINISH) begin
			add_a = gtd_pkg::NET_W'(own_q);
			add_b = net_q;
		end else begin
			add_a = net_q;
			add_b = inflow - outflow;
		end
	end
	assign sum = add_a + add_b;

	always_comb begin
		if (sum < 0) begin
			clamped = '0;
		end else if (sum > gtd_pkg::NET_W'(255)) begin
			clamped = '1;
		end else begin
			clamped = sum[gtd_pkg::LVL_W-1:0];
		end
	end

	assign load_out = (state_q == ST_FINISH) && (!m_valid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			step_q    <= gtd_pkg::STEP_OWN;
			m_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (s_tuser == gtd_pkg::ACT_READ)) begin
						step_q  <= gtd_pkg::STEP_RIGHT;
						state_q <= in_oob ? ST_FINISH : ST_FETCH;
					end
				end
				ST_FETCH: begin
					step_q <= step_q + 1'b1;
					if (step_q == gtd_pkg::STEP_LAST) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_q <= in_col;
			row_q <= in_row;
			oob_q <= in_oob;
		end
		if (state_q == ST_FETCH) begin
			if (proc_step == gtd_pkg::STEP_OWN) begin
				own_q      <= rd_data.level;
				self_blk_q <= rd_data.blocked;
				own_sp_q   <= gtd_pkg::spread_of(rd_data.level, cfg.thr);
				net_q      <= '0;
			end else begin
				net_q <= sum;
			end
		end
		if (load_out) begin
			lvl_out_q <= oob_q ? '0 : clamped;
			changed_q <= !oob_q && (net_q != '0);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'b0, changed_q, lvl_out_q};

	assign status.idle      = state_q == ST_IDLE;
	assign status.finishing = state_q == ST_FINISH;

endmodule
